// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BQJI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BQJI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/bqji_pkg.sv
// shared constants, types and helpers of the quad jacobian inverse unit
`default_nettype none

package bqji_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int REF_FRAC_BITS_DEF   = 14;

    // quotient bits kept by the divider, one above the 2^32 cap
    localparam int QUO_BITS    = 33;
    // divider: setup stage, one stage per quotient bit, format stage
    localparam int DIV_STAGES  = QUO_BITS + 2;
    // stages ahead of the dividers
    localparam int PRE_STAGES  = 6;

    typedef struct packed {
        logic neg;
        logic zero;
    } div_ctl_t;

    function automatic logic [31:0] abs32(input logic signed [31:0] e);
        logic signed [31:0] v;
        v = e[31] ? -e : e;
        return unsigned'(v);
    endfunction

endpackage

`default_nettype wire

// File: rtl/bqji_div.sv
// pipelined restoring divider for one inverse jacobian entry
`default_nettype none

module bqji_div #(
    parameter int COORD_FRAC_BITS = bqji_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [31:0]              num,
    input  logic [62:0]              den,
    input  bqji_pkg::div_ctl_t       ctl,
    output logic signed [31:0]       quo
);

    localparam int SHIFT = 2 * COORD_FRAC_BITS;
    localparam int NUM_W = 32 + SHIFT;
    localparam int QB    = bqji_pkg::QUO_BITS;

    logic [NUM_W-1:0] num_full;
    logic [63:0]      rem_init;

    logic [63:0]        rem_reg [0:QB];
    logic [QB-1:0]      qb_reg  [0:QB];
    logic [QB-1:0]      low_reg [0:QB];
    logic [62:0]        den_reg [0:QB];
    logic               ovf_reg [0:QB];
    bqji_pkg::div_ctl_t ctl_reg [0:QB];

    logic               rnd;
    logic [QB:0]        val;
    logic [QB-1:0]      mag;
    logic signed [31:0] quo_next;
    logic signed [31:0] quo_reg;

    assign num_full = {num, {SHIFT{1'b0}}};
    assign rem_init = 64'(num_full[NUM_W-1:QB]);

    // setup: high part of the dividend and quotient overflow check
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem_init;
            ovf_reg[0] <= rem_init >= {1'b0, den};
            qb_reg[0]  <= '0;
            low_reg[0] <= num_full[QB-1:0];
            den_reg[0] <= den;
            ctl_reg[0] <= ctl;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [63:0] trial;
        logic        ge;
        logic [63:0] rem_next;

        always_comb
        begin
            trial    = {rem_reg[k][62:0], low_reg[k][QB-1]};
            ge       = trial >= {1'b0, den_reg[k]};
            rem_next = ge ? trial - {1'b0, den_reg[k]} : trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                qb_reg[k+1]  <= {qb_reg[k][QB-2:0], ge};
                low_reg[k+1] <= {low_reg[k][QB-2:0], 1'b0};
                den_reg[k+1] <= den_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end
    end

    // round half away, cap at 2^32, apply sign and saturate
    always_comb
    begin
        rnd = {rem_reg[QB][62:0], 1'b0} >= {1'b0, den_reg[QB]};
        val = {1'b0, qb_reg[QB]} + (QB+1)'(rnd);
        if (ovf_reg[QB] || val > (QB+1)'(64'h1_0000_0000))
            mag = QB'(64'h1_0000_0000);
        else
            mag = val[QB-1:0];
        if (ctl_reg[QB].zero)
            quo_next = '0;
        else if (ctl_reg[QB].neg)
            quo_next = (mag >= QB'(64'h8000_0000)) ? 32'sh8000_0000 : -$signed(mag[31:0]);
        else
            quo_next = (mag > QB'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// File: rtl/bilinear_quad_jacobian_inverse_unit.sv
// top level: bilinear quad jacobian, absolute determinant and inverse pipeline
//
// usage
// - input channel in_valid / in_stall carries one cell: four x and four y
//   corners and the reference point; a request is taken when in_valid is
//   high and in_stall is low
// - output channel out_valid / out_stall carries the jacobian, |det|, the
//   four inverse entries and the degenerate flag
// - the pipe has 6 stages for the jacobian and determinant, then 35 stages
//   of the four restoring dividers (setup, one per quotient bit, format)
// - throughput is one request per cycle; the whole pipe moves as one, so
//   a stalled output holds every stage and raises in_stall in that cycle
// - a stalled result stays on the outputs unchanged, nothing is lost
// - reset clears the valid bits only; the pipe comes up empty
// - degenerate is set when |det| is zero, the inverse entries are then zero
`default_nettype none

module bilinear_quad_jacobian_inverse_unit #(
    parameter int COORD_FRAC_BITS = bqji_pkg::COORD_FRAC_BITS_DEF,
    parameter int REF_FRAC_BITS   = bqji_pkg::REF_FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] x_corner_a,
    input  logic signed [31:0] x_corner_b,
    input  logic signed [31:0] x_corner_c,
    input  logic signed [31:0] x_corner_d,
    input  logic signed [31:0] y_corner_a,
    input  logic signed [31:0] y_corner_b,
    input  logic signed [31:0] y_corner_c,
    input  logic signed [31:0] y_corner_d,
    input  logic signed [15:0] ref_first,
    input  logic signed [15:0] ref_second,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] jac_dx_dz1,
    output logic signed [31:0] jac_dx_dz2,
    output logic signed [31:0] jac_dy_dz1,
    output logic signed [31:0] jac_dy_dz2,
    output logic [62:0]        abs_determinant,
    output logic signed [31:0] inv_dz1_dx,
    output logic signed [31:0] inv_dz1_dy,
    output logic signed [31:0] inv_dz2_dx,
    output logic signed [31:0] inv_dz2_dy,
    output logic               degenerate
);

    `include "assert_macros.svh"

    localparam int DW    = 33;
    localparam int ZW    = ((REF_FRAC_BITS + 2 > 16) ? REF_FRAC_BITS + 2 : 16) + 1;
    localparam int PW    = DW + ZW;
    localparam int SW    = PW + 1;
    localparam int SH    = REF_FRAC_BITS + 2;
    localparam int TOTAL = bqji_pkg::PRE_STAGES + bqji_pkg::DIV_STAGES;
    localparam int DLY   = bqji_pkg::DIV_STAGES;
    localparam logic signed [ZW-1:0] ONE_Q = ZW'(2 ** REF_FRAC_BITS);
    localparam logic signed [SW-1:0] RND_Q = SW'(2 ** (SH - 1));

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic [62:0]        adet;
        logic               deg;
    } res_info_t;

    logic             adv;
    logic [TOTAL-1:0] vld_reg;

    logic signed [DW-1:0] dif_next [0:7];
    logic signed [DW-1:0] dif_reg  [0:7];
    logic signed [ZW-1:0] wt_next  [0:3];
    logic signed [ZW-1:0] wt_reg   [0:3];
    logic signed [PW-1:0] prod_reg [0:7];
    logic signed [31:0]   jac_next [0:3];
    logic signed [31:0]   jac3_reg [0:3];
    logic signed [31:0]   jac4_reg [0:3];
    logic signed [31:0]   jac5_reg [0:3];
    logic signed [31:0]   jac6_reg [0:3];
    logic signed [63:0]   ad_reg;
    logic signed [63:0]   bc_reg;
    logic signed [64:0]   det_reg;
    logic signed [64:0]   det_pos;
    logic [62:0]          adet_next;
    logic [62:0]          adet_reg;
    logic                 deg_reg;

    logic [31:0]        num_reg [0:3];
    bqji_pkg::div_ctl_t ctl_reg [0:3];
    logic signed [31:0] quo     [0:3];
    res_info_t          info_reg [0:DLY-1];
    res_info_t          info_out;

    assign adv      = !(vld_reg[TOTAL-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[TOTAL-2:0], in_valid};
    end

    // stage 1: corner differences and shape weights
    always_comb
    begin
        dif_next[0] = DW'(x_corner_b) - DW'(x_corner_a);
        dif_next[1] = DW'(x_corner_d) - DW'(x_corner_c);
        dif_next[2] = DW'(x_corner_c) - DW'(x_corner_a);
        dif_next[3] = DW'(x_corner_d) - DW'(x_corner_b);
        dif_next[4] = DW'(y_corner_b) - DW'(y_corner_a);
        dif_next[5] = DW'(y_corner_d) - DW'(y_corner_c);
        dif_next[6] = DW'(y_corner_c) - DW'(y_corner_a);
        dif_next[7] = DW'(y_corner_d) - DW'(y_corner_b);
        wt_next[0]  = ONE_Q - ZW'(ref_second);
        wt_next[1]  = ONE_Q + ZW'(ref_second);
        wt_next[2]  = ONE_Q - ZW'(ref_first);
        wt_next[3]  = ONE_Q + ZW'(ref_first);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 8; i++)
                dif_reg[i] <= dif_next[i];
            for (int i = 0; i < 4; i++)
                wt_reg[i] <= wt_next[i];
        end
    end

    // stage 2: weighted differences
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 8; i++)
                prod_reg[i] <= PW'(dif_reg[i]) * PW'(wt_reg[i % 4]);
        end
    end

    // stage 3: sum, round ties up, saturate
    for (genvar e = 0; e < 4; e++) begin : g_jac
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] rnd_v;
        logic                 ovf;

        always_comb
        begin
            sum   = SW'(prod_reg[2*e]) + SW'(prod_reg[2*e+1]) + RND_Q;
            rnd_v = sum >>> SH;
            ovf   = !((&rnd_v[SW-1:31]) || !(|rnd_v[SW-1:31]));
            if (ovf)
                jac_next[e] = rnd_v[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            else
                jac_next[e] = rnd_v[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                jac3_reg[i] <= jac_next[i];
        end
    end

    // stage 4: cross products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ad_reg <= 64'(jac3_reg[0]) * 64'(jac3_reg[3]);
            bc_reg <= 64'(jac3_reg[1]) * 64'(jac3_reg[2]);
            for (int i = 0; i < 4; i++)
                jac4_reg[i] <= jac3_reg[i];
        end
    end

    // stage 5: determinant
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_reg <= 65'(ad_reg) - 65'(bc_reg);
            for (int i = 0; i < 4; i++)
                jac5_reg[i] <= jac4_reg[i];
        end
    end

    // stage 6: absolute value, saturation, divider operands
    always_comb
    begin
        det_pos   = det_reg[64] ? -det_reg : det_reg;
        adet_next = (|det_pos[64:63]) ? '1 : det_pos[62:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            adet_reg        <= adet_next;
            deg_reg         <= adet_next == '0;
            num_reg[0]      <= bqji_pkg::abs32(jac5_reg[3]);
            num_reg[1]      <= bqji_pkg::abs32(jac5_reg[1]);
            num_reg[2]      <= bqji_pkg::abs32(jac5_reg[2]);
            num_reg[3]      <= bqji_pkg::abs32(jac5_reg[0]);
            ctl_reg[0].neg  <= jac5_reg[3][31];
            ctl_reg[1].neg  <= !jac5_reg[1][31];
            ctl_reg[2].neg  <= !jac5_reg[2][31];
            ctl_reg[3].neg  <= jac5_reg[0][31];
            for (int i = 0; i < 4; i++)
            begin
                ctl_reg[i].zero <= adet_next == '0;
                jac6_reg[i]     <= jac5_reg[i];
            end
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_div
        bqji_div #(
            .COORD_FRAC_BITS(COORD_FRAC_BITS)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num (num_reg[k]),
            .den (adet_reg),
            .ctl (ctl_reg[k]),
            .quo (quo[k])
        );
    end

    // jacobian and determinant ride alongside the dividers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            info_reg[0] <= '{a: jac6_reg[0], b: jac6_reg[1], c: jac6_reg[2],
                             d: jac6_reg[3], adet: adet_reg, deg: deg_reg};
            for (int i = 1; i < DLY; i++)
                info_reg[i] <= info_reg[i-1];
        end
    end

    assign info_out        = info_reg[DLY-1];
    assign out_valid       = vld_reg[TOTAL-1];
    assign jac_dx_dz1      = info_out.a;
    assign jac_dx_dz2      = info_out.b;
    assign jac_dy_dz1      = info_out.c;
    assign jac_dy_dz2      = info_out.d;
    assign abs_determinant = info_out.adet;
    assign degenerate      = info_out.deg;
    assign inv_dz1_dx      = quo[0];
    assign inv_dz1_dy      = quo[1];
    assign inv_dz2_dx      = quo[2];
    assign inv_dz2_dy      = quo[3];

    `BQJI_ASSERT_IMP(a_deg_zero_inv, out_valid && degenerate,
        inv_dz1_dx == 0 && inv_dz1_dy == 0 && inv_dz2_dx == 0 && inv_dz2_dy == 0)
    `BQJI_ASSERT_IMP(a_deg_matches_det, out_valid,
        degenerate == (abs_determinant == 0))
    `BQJI_ASSERT_IMP(a_inv_sign, out_valid && !degenerate && !jac_dx_dz1[31],
        !inv_dz2_dy[31])
    `BQJI_ASSERT_NEXT(a_bubble_moves, !vld_reg[TOTAL-2] && adv, !out_valid)

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// self-checking testbench for the bilinear quad jacobian inverse unit
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

    localparam int CFB = 16;
    localparam int RFB = 14;
    localparam int LATENCY = 41;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] xa, xb, xc, xd, ya, yb, yc, yd;
        logic signed [15:0] z1, z2;
    } cell_t;

    typedef struct packed {
        logic signed [31:0] a, b, c, d;
        logic [62:0]        adet;
        logic signed [31:0] i0, i1, i2, i3;
        logic               degen;
    } jac_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    cell_t req_item = '0;
    jac_t got;

    jac_t expected_q[$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int degen_seen = 0;
    longint cycles = 0;
    bit idle_on = 1'b1;

    bilinear_quad_jacobian_inverse_unit uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .x_corner_a(req_item.xa), .x_corner_b(req_item.xb),
        .x_corner_c(req_item.xc), .x_corner_d(req_item.xd),
        .y_corner_a(req_item.ya), .y_corner_b(req_item.yb),
        .y_corner_c(req_item.yc), .y_corner_d(req_item.yd),
        .ref_first(req_item.z1), .ref_second(req_item.z2),
        .out_valid(out_valid), .out_stall(out_stall),
        .jac_dx_dz1(got.a), .jac_dx_dz2(got.b),
        .jac_dy_dz1(got.c), .jac_dy_dz2(got.d),
        .abs_determinant(got.adet),
        .inv_dz1_dx(got.i0), .inv_dz1_dy(got.i1),
        .inv_dz2_dx(got.i2), .inv_dz2_dy(got.i3),
        .degenerate(got.degen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint round_shift(input longint t, input int s);
        return (t + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // rounded magnitude of n * 2^(2*CFB) / d, capped at 2^32
    function automatic logic [63:0] quot_mag(input logic [63:0] n, input logic [63:0] d);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        num = {64'd0, n} << (2 * CFB);
        q = num / d;
        r = num % d;
        if ((r << 1) >= d)
            q = q + 1;
        if (q > 128'h1_0000_0000)
            q = 128'h1_0000_0000;
        return q[63:0];
    endfunction

    function automatic logic signed [31:0] inverse_entry(input logic signed [31:0] e,
                                                         input bit negate,
                                                         input logic [63:0] det);
        bit neg;
        logic [63:0] m;
        longint ev;
        ev = e;
        neg = (ev < 0) != negate;
        m = quot_mag(ev < 0 ? -ev : ev, det);
        if (neg)
            return (m >= 64'h8000_0000) ? 32'sh80000000 : -$signed(m[31:0]);
        return (m > 64'h7fff_ffff) ? 32'sh7fffffff : m[31:0];
    endfunction

    function automatic jac_t predict_jacobian(input cell_t c);
        jac_t r;
        longint one;
        longint z1;
        longint z2;
        longint det;
        logic [63:0] ad;
        int sh;
        one = longint'(1) << RFB;
        z1 = c.z1;
        z2 = c.z2;
        sh = RFB + 2;
        r.a = clamp32(round_shift((longint'(c.xb) - c.xa) * (one - z2)
                                + (longint'(c.xd) - c.xc) * (one + z2), sh));
        r.b = clamp32(round_shift((longint'(c.xc) - c.xa) * (one - z1)
                                + (longint'(c.xd) - c.xb) * (one + z1), sh));
        r.c = clamp32(round_shift((longint'(c.yb) - c.ya) * (one - z2)
                                + (longint'(c.yd) - c.yc) * (one + z2), sh));
        r.d = clamp32(round_shift((longint'(c.yc) - c.ya) * (one - z1)
                                + (longint'(c.yd) - c.yb) * (one + z1), sh));
        det = longint'(r.a) * r.d - longint'(r.b) * r.c;
        ad = det < 0 ? -det : det;
        if (ad > 64'h7fff_ffff_ffff_ffff)
            ad = 64'h7fff_ffff_ffff_ffff;
        r.adet = ad[62:0];
        r.degen = (ad == 0);
        r.i0 = 0;
        r.i1 = 0;
        r.i2 = 0;
        r.i3 = 0;
        if (ad != 0)
        begin
            r.i0 = inverse_entry(r.d, 1'b0, ad);
            r.i1 = inverse_entry(r.b, 1'b1, ad);
            r.i2 = inverse_entry(r.c, 1'b1, ad);
            r.i3 = inverse_entry(r.a, 1'b0, ad);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %h actual %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no request pending");
                errors++;
            end
            else
            begin
                jac_t e;
                e = expected_q.pop_front();
                check_field("jac_dx_dz1", e.a, got.a);
                check_field("jac_dx_dz2", e.b, got.b);
                check_field("jac_dy_dz1", e.c, got.c);
                check_field("jac_dy_dz2", e.d, got.d);
                check_field("abs_determinant", e.adet, got.adet);
                check_field("inv_dz1_dx", e.i0, got.i0);
                check_field("inv_dz1_dy", e.i1, got.i1);
                check_field("inv_dz2_dx", e.i2, got.i2);
                check_field("inv_dz2_dy", e.i3, got.i3);
                check_field("degenerate", e.degen, got.degen);
                checked++;
                if (e.degen)
                    degen_seen++;
            end
        end
    end

    // receiver stalls in random bursts
    initial
    begin
        @(posedge rst_n);
        while (1)
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_cell(input cell_t c);
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        req_item <= c;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(predict_jacobian(c));
        sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_ref();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'sd0;
            3: return 16'($urandom);
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    function automatic cell_t rand_cell();
        cell_t c;
        int w;
        w = $urandom_range(0, 3);
        c.xa = $urandom;
        c.xb = $urandom;
        c.xc = $urandom;
        c.xd = $urandom;
        c.ya = $urandom;
        c.yb = $urandom;
        c.yc = $urandom;
        c.yd = $urandom;
        if (w != 0)
        begin
            // well-shaped cell of modest size around a random origin
            logic signed [31:0] ox;
            logic signed [31:0] oy;
            int sz;
            sz = (w == 1) ? 4 : (w == 2 ? 16 : 24);
            ox = $signed($urandom) >>> 4;
            oy = $signed($urandom) >>> 4;
            c.xa = ox + ($signed($urandom) >>> (32 - sz + 2));
            c.ya = oy + ($signed($urandom) >>> (32 - sz + 2));
            c.xb = ox + (1 <<< sz) + ($signed($urandom) >>> (32 - sz + 2));
            c.yb = oy + ($signed($urandom) >>> (32 - sz + 2));
            c.xc = ox + ($signed($urandom) >>> (32 - sz + 2));
            c.yc = oy + (1 <<< sz) + ($signed($urandom) >>> (32 - sz + 2));
            c.xd = ox + (1 <<< sz) + ($signed($urandom) >>> (32 - sz + 2));
            c.yd = oy + (1 <<< sz) + ($signed($urandom) >>> (32 - sz + 2));
        end
        c.z1 = rand_ref();
        c.z2 = rand_ref();
        return c;
    endfunction

    task automatic test_directed();
        cell_t c;
        // unit square
        c = '{0, 32'sh10000, 0, 32'sh10000, 0, 0, 32'sh10000, 32'sh10000, 0, 0};
        send_cell(c);
        c.z1 = 16'sd16384; c.z2 = -16'sd16384;
        send_cell(c);
        c.z1 = 16'sh7fff; c.z2 = 16'sh8000;
        send_cell(c);
        // all corners equal gives zero determinant
        c = '{5, 5, 5, 5, 7, 7, 7, 7, 0, 0};
        send_cell(c);
        // collinear corners, degenerate
        c = '{0, 32'sh10000, 32'sh20000, 32'sh30000, 0, 32'sh10000, 32'sh20000,
              32'sh30000, 16'sd100, -16'sd200};
        send_cell(c);
        // extremes saturate the jacobian
        c = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0, 0};
        send_cell(c);
        c = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
              32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
              16'sh7fff, 16'sh7fff};
        send_cell(c);
        c = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
              32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
              16'sh8000, 16'sh8000};
        send_cell(c);
        // tiny cell, huge inverse saturates
        c = '{0, 1, 0, 1, 0, 0, 1, 1, 0, 0};
        send_cell(c);
        c = '{0, -1, 0, -1, 0, 0, 1, 1, 16'sd16384, 16'sd16384};
        send_cell(c);
        // rounding ties and mirrored cell
        c = '{0, 3, 0, 3, 0, 0, -3, -3, 16'sd8192, -16'sd8192};
        send_cell(c);
        c = '{32'shffffffff, 32'sh0, 32'sh0, 32'shffffffff, 32'shffffffff, 0,
              0, 32'shffffffff, 16'shffff, 16'shffff};
        send_cell(c);
        wait_drained();
    endtask

    task automatic test_random(input int n);
        repeat (n)
            send_cell(rand_cell());
        wait_drained();
    endtask

    task automatic test_no_idle(input int n);
        idle_on = 1'b0;
        // let a running stall burst finish on its own
        while (out_stall)
            @(negedge clk);
        repeat (n)
            send_cell(rand_cell());
        wait_drained();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(500);
        test_random(400);
        test_no_idle(200);
        repeat (LATENCY + 10) @(negedge clk);
        $display("sent %0d cells, checked %0d results, %0d degenerate", sent, checked,
                 degen_seen);
        $display("covered corner extremes, degenerate cells, random meshes, stalls");
        if (errors == 0 && expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/bqji_pkg.sv
rtl/bqji_div.sv
rtl/bilinear_quad_jacobian_inverse_unit.sv
dv/tb_top.sv
